[design/slc_pkg.sv]
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types and constants for the source line classifier.
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int BYTE_W        = 8;
  localparam int RES_W         = 32;
  localparam int RES_FIELDS    = 5;
  localparam int RES_DATA_W    = RES_W * RES_FIELDS;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 8;
  localparam int COUNT_WIDTH_D = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LM_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LM_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LM_LEN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLK_EN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BO_FIRST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BO_SECOND = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BC_FIRST  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BC_SECOND = 3'd7;

  // character codes
  localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CHAR_STAR  = 8'h2A;

  typedef struct packed {
    logic [BYTE_W-1:0] lm_first;
    logic [BYTE_W-1:0] lm_second;
    logic [1:0]        lm_len;
    logic              blk_en;
    logic [BYTE_W-1:0] bo_first;
    logic [BYTE_W-1:0] bo_second;
    logic [BYTE_W-1:0] bc_first;
    logic [BYTE_W-1:0] bc_second;
  } cfg_t;

  // per-line scanner flags
  typedef struct packed {
    logic has_code;
    logic has_comment;
    logic in_line;
    logic in_block;
    logic line_open;
  } flags_t;

  // one line ending: at most one class bit set
  typedef struct packed {
    logic code;
    logic comment;
    logic blank;
  } line_ev_t;

  // line endings caused by one word: held byte, final byte, open last line
  typedef struct packed {
    line_ev_t held;
    line_ev_t tail;
    line_ev_t close;
  } line_evs_t;

  // result word, first field in the highest bits
  typedef struct packed {
    logic [RES_W-1:0] byte_count;
    logic [RES_W-1:0] blank_lines;
    logic [RES_W-1:0] comment_lines;
    logic [RES_W-1:0] code_lines;
    logic [RES_W-1:0] total_lines;
  } result_t;

endpackage

[design/source_line_classifier.sv]
// ----------------------------------------------------------------------------
// source_line_classifier
// Sorts the lines of a source file as code, comment-only or blank.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one file byte per word, with s_tlast on the file's
//   final byte. Each line is classed as code, comment-only or blank using the
//   comment markers in the configuration registers (a line marker of zero to
//   two bytes, and two-byte block open and close markers). Two-byte markers
//   are matched with a one-byte lookahead, so a byte is scanned when the byte
//   after it arrives.
//   On the final byte one result word leaves on the m_ channel: total, code,
//   comment and blank line counts and the byte count, each saturating at
//   all ones. All counts and line state are then cleared for the next file.
// Throughput and flow:
//   One byte per cycle sustained, except while a final byte waits in the input
//   register for the output register to drain. A word sits in the input register
//   while the scanner step and counter update run; the result word is registered
//   into the output register as the final byte leaves the input register.
// Reset and stall:
//   Reset restores C-style markers and clears counts, line state and both
//   registers. While m_tready is low a result is held in the output register;
//   bytes keep flowing until the next final byte reaches the input register,
//   which then waits for the output register to drain.
// Configuration:
//   cfg_wr_en writes cfg_data to register cfg_index; write only while idle.
// ----------------------------------------------------------------------------
module source_line_classifier #(
  parameter int COUNT_WIDTH = slc_pkg::COUNT_WIDTH_D
) (
  input  logic                           clk,
  input  logic                           rst,
  // slave side: [7:0] text_byte
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [slc_pkg::BYTE_W-1:0]     s_tdata,
  input  logic                           s_tlast,
  // master side: [31:0] total_lines, [63:32] code_lines, [95:64] comment_lines,
  //              [127:96] blank_lines, [159:128] byte_count
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [slc_pkg::RES_DATA_W-1:0] m_tdata,
  // configuration write port
  input  logic                           cfg_wr_en,
  input  logic [slc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import slc_pkg::*;

  cfg_t              cfg;

  // input register
  logic              in_full;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  // scanner state
  flags_t            flags;
  flags_t            flags_next;
  logic [BYTE_W-1:0] held_byte;
  logic              held_valid;
  logic              held_valid_next;
  line_evs_t         evs;

  // output register
  logic              out_full;
  result_t           result;
  result_t           out_data;

  logic              advance;

  // the final byte may only move on when the output register is free or draining
  assign advance  = in_full && (!in_last || !out_full || m_tready);
  assign s_tready = !in_full || advance;
  assign m_tvalid = out_full;
  assign m_tdata  = out_data;

  slc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slc_scan u_scan (
    .cfg             (cfg),
    .flags           (flags),
    .held_byte       (held_byte),
    .held_valid      (held_valid),
    .text_byte       (in_byte),
    .end_of_file     (in_last),
    .flags_next      (flags_next),
    .held_valid_next (held_valid_next),
    .evs             (evs)
  );

  slc_counters #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_counters (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .end_of_file (in_last),
    .evs         (evs),
    .result      (result)
  );

  // capture a word whenever the input register frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // advance the scanner state by one byte
  always_ff @(posedge clk) begin
    if (rst) begin
      flags      <= '0;
      held_valid <= 1'b0;
      held_byte  <= '0;
    end else if (advance) begin
      flags      <= flags_next;
      held_valid <= held_valid_next;
      held_byte  <= in_last ? '0 : in_byte;
    end
  end

  // hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance && in_last) begin
      out_full <= 1'b1;
    end else if (m_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_data <= result;
    end
  end

endmodule

[design/slc_cfg.sv]
// ----------------------------------------------------------------------------
// slc_cfg
// Comment marker registers, written through a plain write port.
// ----------------------------------------------------------------------------
module slc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [slc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slc_pkg::CFG_DATA_W-1:0] cfg_data,
  output slc_pkg::cfg_t                  cfg
);
  import slc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lm_first  <= CHAR_SLASH;
      cfg.lm_second <= CHAR_SLASH;
      cfg.lm_len    <= 2'd2;
      cfg.blk_en    <= 1'b1;
      cfg.bo_first  <= CHAR_SLASH;
      cfg.bo_second <= CHAR_STAR;
      cfg.bc_first  <= CHAR_STAR;
      cfg.bc_second <= CHAR_SLASH;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LM_FIRST:  cfg.lm_first  <= cfg_data;
        CFG_LM_SECOND: cfg.lm_second <= cfg_data;
        CFG_LM_LEN:    cfg.lm_len    <= cfg_data[1:0];
        CFG_BLK_EN:    cfg.blk_en    <= cfg_data[0];
        CFG_BO_FIRST:  cfg.bo_first  <= cfg_data;
        CFG_BO_SECOND: cfg.bo_second <= cfg_data;
        CFG_BC_FIRST:  cfg.bc_first  <= cfg_data;
        CFG_BC_SECOND: cfg.bc_second <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[design/slc_scan.sv]
// ----------------------------------------------------------------------------
// slc_scan
// Per-word scanner step: scans the held byte against the new byte as
// lookahead, and on the final byte scans that byte and closes the last line.
// ----------------------------------------------------------------------------
module slc_scan (
  input  slc_pkg::cfg_t                cfg,
  input  slc_pkg::flags_t              flags,
  input  logic [slc_pkg::BYTE_W-1:0]   held_byte,
  input  logic                         held_valid,
  input  logic [slc_pkg::BYTE_W-1:0]   text_byte,
  input  logic                         end_of_file,
  output slc_pkg::flags_t              flags_next,
  output logic                         held_valid_next,
  output slc_pkg::line_evs_t           evs
);
  import slc_pkg::*;

  typedef struct packed {
    flags_t   f;
    logic     consumed;
    line_ev_t ev;
  } scan_res_t;

  function automatic line_ev_t line_class(flags_t f);
    line_ev_t e;
    e.code    = f.has_code;
    e.comment = !f.has_code && (f.has_comment || f.in_block);
    e.blank   = !f.has_code && !f.has_comment && !f.in_block;
    return e;
  endfunction

  function automatic scan_res_t scan_one(flags_t f, cfg_t c, logic [BYTE_W-1:0] ch,
                                         logic [BYTE_W-1:0] la, logic la_ok);
    scan_res_t r;
    logic      ok;
    r.f        = f;
    r.consumed = 1'b0;
    r.ev       = '0;
    ok         = la_ok && (la != CHAR_NL);
    if (ch == CHAR_NL) begin
      r.ev            = line_class(f);
      r.f.has_code    = 1'b0;
      r.f.has_comment = 1'b0;
      r.f.in_line     = 1'b0;
      r.f.line_open   = 1'b0;
    end else begin
      r.f.line_open = 1'b1;
      if (f.in_block) begin
        r.f.has_comment = 1'b1;
        if (c.blk_en && ch == c.bc_first && ok && la == c.bc_second) begin
          r.f.in_block = 1'b0;
          r.consumed   = 1'b1;
        end
      end else if (f.in_line) begin
        r.consumed = 1'b0;
      end else if (c.lm_len == 2'd1 && ch == c.lm_first) begin
        r.f.in_line     = 1'b1;
        r.f.has_comment = 1'b1;
      end else if (c.lm_len[1] && ch == c.lm_first && ok && la == c.lm_second) begin
        r.f.in_line     = 1'b1;
        r.f.has_comment = 1'b1;
        r.consumed      = 1'b1;
      end else if (c.blk_en && ch == c.bo_first && ok && la == c.bo_second) begin
        r.f.in_block    = 1'b1;
        r.f.has_comment = 1'b1;
        r.consumed      = 1'b1;
      end else if (ch != CHAR_SPACE && ch != CHAR_TAB) begin
        r.f.has_code = 1'b1;
      end
    end
    return r;
  endfunction

  scan_res_t s1;
  scan_res_t s2;

  always_comb begin
    s1 = '{f: flags, consumed: 1'b0, ev: '0};
    if (held_valid) begin
      s1 = scan_one(flags, cfg, held_byte, text_byte, 1'b1);
    end
    // final byte: scan it with no lookahead unless the held byte took it
    s2 = '{f: s1.f, consumed: 1'b0, ev: '0};
    if (!s1.consumed) begin
      s2 = scan_one(s1.f, cfg, text_byte, '0, 1'b0);
    end

    evs.held  = s1.ev;
    evs.tail  = end_of_file ? s2.ev : '0;
    evs.close = (end_of_file && s2.f.line_open) ? line_class(s2.f) : '0;

    flags_next      = end_of_file ? '0 : s1.f;
    held_valid_next = !end_of_file && !s1.consumed;
  end

endmodule

[design/slc_counters.sv]
// ----------------------------------------------------------------------------
// slc_counters
// Saturating line and byte counters with the result word built from them.
// ----------------------------------------------------------------------------
module slc_counters #(
  parameter int COUNT_WIDTH = slc_pkg::COUNT_WIDTH_D
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               end_of_file,
  input  slc_pkg::line_evs_t evs,
  output slc_pkg::result_t   result
);
  import slc_pkg::*;

  logic [COUNT_WIDTH-1:0] total_count;
  logic [COUNT_WIDTH-1:0] code_count;
  logic [COUNT_WIDTH-1:0] comment_count;
  logic [COUNT_WIDTH-1:0] blank_count;
  logic [COUNT_WIDTH-1:0] bytes_seen;

  logic [COUNT_WIDTH-1:0] total_next;
  logic [COUNT_WIDTH-1:0] code_next;
  logic [COUNT_WIDTH-1:0] comment_next;
  logic [COUNT_WIDTH-1:0] blank_next;
  logic [COUNT_WIDTH-1:0] bytes_next;

  logic [1:0] code_inc;
  logic [1:0] comment_inc;
  logic [1:0] blank_inc;
  logic [1:0] total_inc;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(logic [COUNT_WIDTH-1:0] v,
                                                     logic [1:0] inc);
    logic [COUNT_WIDTH:0] sum;
    sum = {1'b0, v} + (COUNT_WIDTH+1)'(inc);
    return sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
  endfunction

  // clamp to the 32-bit result field
  function automatic logic [RES_W-1:0] to_res(logic [COUNT_WIDTH-1:0] v);
    logic [63:0] ext;
    ext = 64'(v);
    return (ext[63:RES_W] != '0) ? {RES_W{1'b1}} : ext[RES_W-1:0];
  endfunction

  always_comb begin
    code_inc    = {1'b0, evs.held.code} + {1'b0, evs.tail.code} + {1'b0, evs.close.code};
    comment_inc = {1'b0, evs.held.comment} + {1'b0, evs.tail.comment}
                + {1'b0, evs.close.comment};
    blank_inc   = {1'b0, evs.held.blank} + {1'b0, evs.tail.blank} + {1'b0, evs.close.blank};
    total_inc   = code_inc + comment_inc + blank_inc;

    total_next   = sat_add(total_count, total_inc);
    code_next    = sat_add(code_count, code_inc);
    comment_next = sat_add(comment_count, comment_inc);
    blank_next   = sat_add(blank_count, blank_inc);
    bytes_next   = sat_add(bytes_seen, 2'd1);

    result.total_lines   = to_res(total_next);
    result.code_lines    = to_res(code_next);
    result.comment_lines = to_res(comment_next);
    result.blank_lines   = to_res(blank_next);
    result.byte_count    = to_res(bytes_next);
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && end_of_file)) begin
      total_count   <= '0;
      code_count    <= '0;
      comment_count <= '0;
      blank_count   <= '0;
      bytes_seen    <= '0;
    end else if (advance) begin
      total_count   <= total_next;
      code_count    <= code_next;
      comment_count <= comment_next;
      blank_count   <= blank_next;
      bytes_seen    <= bytes_next;
    end
  end

endmodule

[design/slc_checker.sv]
// ----------------------------------------------------------------------------
// slc_checker
// Port-level checks for the source line classifier, bound to the top level.
// ----------------------------------------------------------------------------
module slc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [slc_pkg::RES_DATA_W-1:0] m_tdata
);
  import slc_pkg::*;

  result_t res;
  assign res = m_tdata;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // nothing leaves straight after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // every file holds at least one byte and one line
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.total_lines != '0) && (res.byte_count != '0))
    else $error("empty result");

  // each class count stays within the total, total within the byte count
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.code_lines <= res.total_lines) &&
                 (res.comment_lines <= res.total_lines) &&
                 (res.blank_lines <= res.total_lines) &&
                 (res.total_lines <= res.byte_count))
    else $error("inconsistent line counts");

endmodule

bind source_line_classifier slc_checker u_slc_checker (.*);
